// ----- hdl/hsv2rgb_pkg.sv -----
// Shared types and constants for the HSV to RGB pixel converter.
// Fixed-point formats, pixel structs, stage payloads and the percent lookup.
// No dependencies.
`default_nettype none

package hsv2rgb_pkg;

  // Fixed-point fraction bits (UQ1.F for s, v, C, X, m)
  localparam int FRAC_BITS  = 16;
  localparam int HUE_MAX    = 360;
  localparam int PCT_MAX    = 100;
  localparam int CHAN_MAX   = 255;
  localparam int SECTOR_DEG = 60;

  // C * k with k <= 60 stays below 2^(F+6)
  localparam int PROD_W    = FRAC_BITS + 6;
  // Floor reciprocal of 60 at PROD_W fraction bits, below 2^(F+1)
  localparam int RECIP_W   = FRAC_BITS + 1;
  localparam logic [RECIP_W-1:0] RECIP_60 =
    RECIP_W'((64'd1 << PROD_W) / SECTOR_DEG);

  typedef logic [FRAC_BITS:0] ufix_t;
  typedef logic [5:0]         ramp_t;   // 0..60 across a sector
  typedef logic [PROD_W-1:0]  prod_t;

  // 60-degree hue sectors; WRAP is exactly 360 degrees
  typedef enum logic [2:0] {
    SEC_RY   = 3'd0,
    SEC_YG   = 3'd1,
    SEC_GC   = 3'd2,
    SEC_CB   = 3'd3,
    SEC_BM   = 3'd4,
    SEC_MR   = 3'd5,
    SEC_WRAP = 3'd6
  } sector_t;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] val_pct;
  } hsv_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       range_error;
  } rgb_pixel_t;

  // Prep stage result
  typedef struct packed {
    ufix_t   s;
    ufix_t   v;
    ramp_t   k;
    sector_t sector;
    logic    err;
  } prep_t;

  // Chroma stage result
  typedef struct packed {
    ufix_t   c;
    ufix_t   x;
    ufix_t   m;
    sector_t sector;
    logic    err;
  } chroma_t;

  // Percent to UQ1.F, floor(p * 2^F / 100); only entries 0..100 are reached
  typedef ufix_t pct_lut_t [128];

  function automatic pct_lut_t build_pct_lut();
    pct_lut_t lut;
    for (int i = 0; i < 128; i++) begin
      lut[i] = ufix_t'((64'(i) << FRAC_BITS) / PCT_MAX);
    end
    return lut;
  endfunction

  localparam pct_lut_t PCT_LUT = build_pct_lut();

endpackage

`default_nettype wire

// ----- hdl/hsv2rgb_prep.sv -----
// First pipeline stage: clamp inputs, look up s and v, find sector and ramp.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_prep
  import hsv2rgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire hsv_pixel_t pix,
  output logic            out_valid,
  input  wire logic       out_ready,
  output prep_t           prep
);

  localparam logic [8:0] HueMax  = 9'(HUE_MAX);
  localparam logic [6:0] PctMax  = 7'(PCT_MAX);
  localparam logic [8:0] Deg60   = 9'(SECTOR_DEG);
  localparam logic [8:0] Deg120  = 9'(2 * SECTOR_DEG);
  localparam logic [8:0] Deg180  = 9'(3 * SECTOR_DEG);
  localparam logic [8:0] Deg240  = 9'(4 * SECTOR_DEG);
  localparam logic [8:0] Deg300  = 9'(5 * SECTOR_DEG);
  localparam logic [6:0] Ramp60  = 7'(SECTOR_DEG);
  localparam logic [6:0] Ramp120 = 7'(2 * SECTOR_DEG);

  logic       go;
  logic [8:0] hue_c;
  logic [6:0] sat_c;
  logic [6:0] val_c;
  logic [8:0] base;
  logic [6:0] d;
  prep_t      prep_next;

  assign go       = !out_valid || out_ready;
  assign in_ready = go;

  // Clamp, classify the hue and fold it into a 0..60..0 ramp
  always_comb begin
    hue_c = (pix.hue_deg > HueMax) ? HueMax : pix.hue_deg;
    sat_c = (pix.sat_pct > PctMax) ? PctMax : pix.sat_pct;
    val_c = (pix.val_pct > PctMax) ? PctMax : pix.val_pct;

    if (hue_c >= HueMax)      prep_next.sector = SEC_WRAP;
    else if (hue_c >= Deg300) prep_next.sector = SEC_MR;
    else if (hue_c >= Deg240) prep_next.sector = SEC_BM;
    else if (hue_c >= Deg180) prep_next.sector = SEC_CB;
    else if (hue_c >= Deg120) prep_next.sector = SEC_GC;
    else if (hue_c >= Deg60)  prep_next.sector = SEC_YG;
    else                      prep_next.sector = SEC_RY;

    // Start of the 120-degree span that holds the hue
    case (prep_next.sector)
      SEC_RY, SEC_YG: base = 9'd0;
      SEC_GC, SEC_CB: base = Deg120;
      SEC_BM, SEC_MR: base = Deg240;
      SEC_WRAP:       base = HueMax;
      default:        base = 9'd0;
    endcase

    d = 7'(hue_c - base);
    prep_next.k   = (d >= Ramp60) ? ramp_t'(Ramp120 - d) : ramp_t'(d);
    prep_next.s   = PCT_LUT[sat_c];
    prep_next.v   = PCT_LUT[val_c];
    prep_next.err = (pix.hue_deg > HueMax) || (pix.sat_pct > PctMax) ||
                    (pix.val_pct > PctMax);
  end

  // Advance when the next stage has room
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= in_valid;
    end
    if (go && in_valid) begin
      prep <= prep_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_chroma.sv -----
// Chroma stages: C = s*v, m = v - C, X = C*k/60 by reciprocal and correction.
// Four register stages; depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_chroma
  import hsv2rgb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire prep_t   prep,
  output logic         out_valid,
  input  wire logic    out_ready,
  output chroma_t      chroma
);

  localparam prod_t Div60 = PROD_W'(SECTOR_DEG);

  // Stage registers
  logic    v2, v3, v4;
  logic    go2, go3, go4, go5;

  ufix_t   c2, v_2;
  ramp_t   k2;
  sector_t sec2, sec3, sec4;
  logic    err2, err3, err4;

  ufix_t   c3, m3, c4, m4;
  prod_t   p3, p4;
  ufix_t   q4;

  logic [2*FRAC_BITS+1:0]      cv_prod;
  logic [PROD_W+RECIP_W-1:0]   recip_prod;
  prod_t                       q_times;
  prod_t                       rem5;

  assign go5      = !out_valid || out_ready;
  assign go4      = !v4 || go5;
  assign go3      = !v3 || go4;
  assign go2      = !v2 || go3;
  assign in_ready = go2;

  always_comb begin
    cv_prod    = (2*FRAC_BITS+2)'(prep.s) * (2*FRAC_BITS+2)'(prep.v);
    recip_prod = (PROD_W+RECIP_W)'(p3) * (PROD_W+RECIP_W)'(RECIP_60);
    q_times    = prod_t'(q4) * Div60;
    rem5       = p4 - q_times;
  end

  // Advance valid bits through the four stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go2) v2 <= in_valid;
      if (go3) v3 <= v2;
      if (go4) v4 <= v3;
      if (go5) out_valid <= v4;
    end
  end

  // Stage 2: chroma product
  always_ff @(posedge clk) begin
    if (go2 && in_valid) begin
      c2   <= cv_prod[2*FRAC_BITS:FRAC_BITS];
      v_2  <= prep.v;
      k2   <= prep.k;
      sec2 <= prep.sector;
      err2 <= prep.err;
    end
  end

  // Stage 3: offset and ramp product
  always_ff @(posedge clk) begin
    if (go3 && v2) begin
      c3   <= c2;
      m3   <= v_2 - c2;
      p3   <= prod_t'(c2) * prod_t'(k2);
      sec3 <= sec2;
      err3 <= err2;
    end
  end

  // Stage 4: quotient estimate, at most one short
  always_ff @(posedge clk) begin
    if (go4 && v3) begin
      c4   <= c3;
      m4   <= m3;
      p4   <= p3;
      q4   <= recip_prod[PROD_W+RECIP_W-1:PROD_W];
      sec4 <= sec3;
      err4 <= err3;
    end
  end

  // Stage 5: correct the quotient from the remainder
  always_ff @(posedge clk) begin
    if (go5 && v4) begin
      chroma.c      <= c4;
      chroma.m      <= m4;
      chroma.x      <= (rem5 >= Div60) ? ufix_t'(q4 + 1'b1) : q4;
      chroma.sector <= sec4;
      chroma.err    <= err4;
    end
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v4 |-> rem5 < 2 * Div60)
    else $error("quotient estimate off by more than one");

  a_x_le_c: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chroma.x <= chroma.c)
    else $error("secondary component exceeds chroma");

  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && chroma.sector == SEC_WRAP |-> chroma.x == '0)
    else $error("hue of 360 gave a nonzero secondary component");
`endif

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_mix.sv -----
// Output stage: order components by sector, add offset, scale by 255.
// Holds the output register; depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mix
  import hsv2rgb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire chroma_t chroma,
  output logic         out_valid,
  input  wire logic    out_ready,
  output rgb_pixel_t   rgb
);

  localparam int SCALE_W = FRAC_BITS + 9;

  logic       go;
  ufix_t      r_comp, g_comp, b_comp;
  rgb_pixel_t rgb_next;

  // Scale UQ1.F to 0..255 with truncation, saturated
  function automatic logic [7:0] scale_channel(ufix_t q);
    logic [SCALE_W-1:0] prod;
    logic [8:0]         whole;
    prod  = SCALE_W'(q) * SCALE_W'(CHAN_MAX);
    whole = prod[SCALE_W-1:FRAC_BITS];
    return (whole > 9'(CHAN_MAX)) ? 8'(CHAN_MAX) : whole[7:0];
  endfunction

  assign go       = !out_valid || out_ready;
  assign in_ready = go;

  // Pick the component order for the sector
  always_comb begin
    case (chroma.sector)
      SEC_RY: begin
        r_comp = chroma.c; g_comp = chroma.x; b_comp = '0;
      end
      SEC_YG: begin
        r_comp = chroma.x; g_comp = chroma.c; b_comp = '0;
      end
      SEC_GC: begin
        r_comp = '0; g_comp = chroma.c; b_comp = chroma.x;
      end
      SEC_CB: begin
        r_comp = '0; g_comp = chroma.x; b_comp = chroma.c;
      end
      SEC_BM: begin
        r_comp = chroma.x; g_comp = '0; b_comp = chroma.c;
      end
      SEC_MR, SEC_WRAP: begin
        r_comp = chroma.c; g_comp = '0; b_comp = chroma.x;
      end
      default: begin
        r_comp = chroma.c; g_comp = '0; b_comp = chroma.x;
      end
    endcase

    rgb_next.red         = scale_channel(ufix_t'(r_comp + chroma.m));
    rgb_next.green       = scale_channel(ufix_t'(g_comp + chroma.m));
    rgb_next.blue        = scale_channel(ufix_t'(b_comp + chroma.m));
    rgb_next.range_error = chroma.err;
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= in_valid;
    end
    if (go && in_valid) begin
      rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hsv2rgb_converter_top.sv -----
// Top level of the HSV to RGB pixel converter.
// Instantiates hsv2rgb_prep, hsv2rgb_chroma and hsv2rgb_mix; uses hsv2rgb_pkg.
//
//   channel   valid       stall       payload
//   input     hsv_valid   hsv_stall   hsv  (hue_deg, sat_pct, val_pct)
//   output    rgb_valid   rgb_stall   rgb  (red, green, blue, range_error)
//
// An input transfer reaches the output through the six-stage pipeline (prep,
// four chroma stages with the two multiplies and the divide-by-60 reciprocal,
// mix); one pixel per clock is sustained while rgb_stall is low.
// Synchronous reset empties every stage; no pixel is in flight afterward.
// A stall on the output holds the output register; bubbles inside the
// pipeline still close up, so input transfers continue until it is full.
`default_nettype none

module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       hsv_valid,
  output logic            hsv_stall,
  input  wire hsv_pixel_t hsv,
  output logic            rgb_valid,
  input  wire logic       rgb_stall,
  output rgb_pixel_t      rgb
);

  logic    prep_ready;
  logic    prep_valid;
  prep_t   prep;
  logic    chroma_ready;
  logic    chroma_valid;
  chroma_t chroma;
  logic    mix_ready;

  assign hsv_stall = !prep_ready;

  hsv2rgb_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv_valid),
    .in_ready  (prep_ready),
    .pix       (hsv),
    .out_valid (prep_valid),
    .out_ready (chroma_ready),
    .prep      (prep)
  );

  hsv2rgb_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (chroma_ready),
    .prep      (prep),
    .out_valid (chroma_valid),
    .out_ready (mix_ready),
    .chroma    (chroma)
  );

  hsv2rgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chroma_valid),
    .in_ready  (mix_ready),
    .chroma    (chroma),
    .out_valid (rgb_valid),
    .out_ready (!rgb_stall),
    .rgb       (rgb)
  );

endmodule

`default_nettype wire
